@@ design/swsr_pkg.sv @@
// swsr_pkg: shared types, constants and helpers for the stream word search/replace block
// no dependencies; imported by every module of the block
`default_nettype none

package swsr_pkg;

  localparam int MAX_PATTERN_DEF = 8;
  localparam int COUNT_BITS_DEF  = 16;
  localparam int RESULT_LIMIT    = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int MATCH_W         = 16;

  localparam logic [7:0] UNDERSCORE = 8'h5F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_PATTERN  = 3'd0,
    REG_SEARCH_LENGTH   = 3'd1,
    REG_REPLACE_PATTERN = 3'd2,
    REG_REPLACE_LENGTH  = 3'd3,
    REG_MATCH_ANYWHERE  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               byte_valid;
    logic               last_of_stream;
    logic [MATCH_W-1:0] match_count;
  } out_item_t;

  // request from the window control to the output queue
  typedef struct packed {
    logic      push;
    logic      held;
    logic      seal;
    out_item_t item;
  } oq_req_t;

  function automatic logic is_word(input logic [7:0] b);
    logic r;
    r = (b != UNDERSCORE) &&
        (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/stream_word_search_replace_top.sv @@
// stream_word_search_replace_top: byte stream search and replace, whole-word or anywhere
// depends on swsr_pkg, swsr_cell, swsr_outq
`default_nettype none

// Bytes enter one per cycle while in_stall is low, into a row of MAX_PATTERN+1 window cells;
// each cell compares its byte with its pattern byte, and one decision on the head of the
// window is made per cycle while the output queue can take an item. A match with a
// replacement longer than one byte holds the input while the replacement bytes leave one
// per cycle. On the final byte of a stream the input is held while the window drains, one
// decision or replacement byte per cycle, and then the stream is closed. Results pass
// through a pending slot and then the output register; the output register lets a new
// byte be taken while a result waits.

module stream_word_search_replace_top import swsr_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data
);

  localparam int NCELL = MAX_PATTERN + 1;
  localparam int FW    = $clog2(NCELL + 1);
  localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SW    = $clog2(RESULT_LIMIT + 1);
  localparam int BW    = SW + 2;

  logic [CFG_DATA_W-1:0] search_pattern;
  logic [3:0]            search_length;
  logic [CFG_DATA_W-1:0] replace_pattern;
  logic [3:0]            replace_length;
  logic                  match_anywhere;

  logic [FW-1:0]         fill;
  logic [FW-1:0]         emit_cnt;
  logic [IW-1:0]         emit_idx;
  logic                  end_active;
  logic                  step_live;
  logic [SW-1:0]         step_n;
  logic [COUNT_BITS-1:0] tally;
  logic                  prev_word;

  logic [FW-1:0]         len_e;
  logic [FW-1:0]         rlen_e;
  logic [7:0]            win [NCELL];
  logic [7:0]            din [NCELL];
  logic [NCELL-1:0]      eq;
  logic [NCELL-1:0]      word;
  logic [NCELL-1:0]      ld;

  logic                  emitting;
  logic                  win_pend;
  logic                  dec_pend;
  logic                  cmp_ok;
  logic                  word_len;
  logic                  word_last;
  logic                  budget_ok;
  logic                  hit;
  logic                  can_push;
  logic                  do_emit;
  logic                  do_dec;
  logic                  do_done;
  logic                  q_emit;
  logic                  q_dec;
  logic                  ready;
  logic                  accept;
  logic [FW-1:0]         drop;
  logic [FW-1:0]         app_pos;
  logic [COUNT_BITS-1:0] tally_upd;
  logic [IW-1:0]         rep_idx;
  logic [7:0]            rep_byte;
  logic [MATCH_W-1:0]    cnt16;
  oq_req_t               req;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern  <= '0;
      search_length   <= 4'd1;
      replace_pattern <= '0;
      replace_length  <= 4'd0;
      match_anywhere  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEARCH_PATTERN:  search_pattern  <= cfg_data;
        REG_SEARCH_LENGTH:   search_length   <= cfg_data[3:0];
        REG_REPLACE_PATTERN: replace_pattern <= cfg_data;
        REG_REPLACE_LENGTH:  replace_length  <= cfg_data[3:0];
        REG_MATCH_ANYWHERE:  match_anywhere  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (search_length == 4'd0) begin
      len_e = FW'(1);
    end else if (search_length > 4'(MAX_PATTERN)) begin
      len_e = FW'(MAX_PATTERN);
    end else begin
      len_e = FW'(search_length);
    end
    if (replace_length > 4'(MAX_PATTERN)) begin
      rlen_e = FW'(MAX_PATTERN);
    end else begin
      rlen_e = FW'(replace_length);
    end
  end

  // window cells
  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    logic [7:0] pat_b;
    if (gi < MAX_PATTERN) begin : g_pat
      assign pat_b = search_pattern[8*gi +: 8];
    end else begin : g_nopat
      assign pat_b = 8'h00;
    end
    swsr_cell u_cell (
      .clk  (clk),
      .ld   (ld[gi]),
      .din  (din[gi]),
      .pat  (pat_b),
      .data (win[gi]),
      .eq   (eq[gi]),
      .word (word[gi])
    );
  end

  // head decision
  always_comb begin
    cmp_ok    = 1'b1;
    word_len  = 1'b0;
    word_last = 1'b0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FW'(i) < len_e && !eq[i]) begin
        cmp_ok = 1'b0;
      end
      if (len_e == FW'(i + 1)) begin
        word_last = word[i];
      end
    end
    for (int j = 0; j < NCELL; j++) begin
      if (len_e == FW'(j)) begin
        word_len = word[j];
      end
    end
  end

  // decisions run only inside a step opened by an accepted byte
  assign emitting  = (emit_cnt != '0);
  assign win_pend  = (fill != '0) && (end_active || fill > len_e);
  assign dec_pend  = step_live && win_pend;
  assign budget_ok = (BW'(step_n) + BW'(rlen_e) + BW'(fill - len_e)) <= BW'(RESULT_LIMIT);
  assign hit       = (fill >= len_e) && budget_ok && cmp_ok &&
                     (match_anywhere || (!prev_word && !(fill > len_e && word_len)));

  assign do_emit = emitting && can_push;
  assign do_dec  = !emitting && dec_pend && can_push;
  assign do_done = !emitting && !dec_pend && end_active && (step_n != '0 || can_push);

  assign q_emit = (emit_cnt == FW'(1)) && !dec_pend;
  assign q_dec  = hit ? (rlen_e <= FW'(1) && (fill - len_e) <= len_e)
                      : ((fill - FW'(1)) <= len_e);
  assign ready  = !end_active &&
                  ((!emitting && !dec_pend) || (do_emit && q_emit) || (do_dec && q_dec));
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  assign drop    = do_dec ? (hit ? len_e : FW'(1)) : '0;
  assign app_pos = fill - drop;

  assign tally_upd = (do_dec && hit && tally != '1) ? tally + COUNT_BITS'(1) : tally;

  if (COUNT_BITS >= MATCH_W) begin : g_cnt_wide
    assign cnt16 = tally_upd[MATCH_W-1:0];
  end else begin : g_cnt_narrow
    assign cnt16 = {{(MATCH_W - COUNT_BITS){1'b0}}, tally_upd};
  end

  assign rep_idx  = do_emit ? emit_idx : '0;
  assign rep_byte = replace_pattern[{rep_idx, 3'b000} +: 8];

  // window shift and append
  always_comb begin
    for (int i = 0; i < NCELL; i++) begin
      ld[i]  = 1'b0;
      din[i] = in_data.data_byte;
      if (accept && app_pos == FW'(i)) begin
        ld[i] = 1'b1;
      end else begin
        for (int j = 1; j < NCELL - i; j++) begin
          if (drop == FW'(j)) begin
            ld[i]  = 1'b1;
            din[i] = win[i + j];
          end
        end
      end
    end
  end

  // item toward the output queue
  always_comb begin
    req                     = '0;
    req.item.match_count    = cnt16;
    req.item.byte_valid     = 1'b1;
    req.held                = end_active;
    if (do_emit) begin
      req.push          = 1'b1;
      req.item.out_byte = rep_byte;
    end else if (do_dec) begin
      if (hit) begin
        req.push          = (rlen_e != '0);
        req.item.out_byte = rep_byte;
      end else begin
        req.push          = 1'b1;
        req.item.out_byte = win[0];
      end
    end else if (do_done) begin
      req.held = 1'b0;
      if (step_n == '0) begin
        req.push                = 1'b1;
        req.item.byte_valid     = 1'b0;
        req.item.last_of_stream = 1'b1;
      end else begin
        req.seal = 1'b1;
      end
    end
  end

  swsr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      emit_cnt   <= '0;
      emit_idx   <= '0;
      end_active <= 1'b0;
      step_live  <= 1'b0;
      step_n     <= '0;
      tally      <= '0;
      prev_word  <= 1'b0;
    end else begin
      fill <= app_pos + (accept ? FW'(1) : FW'(0));
      if (accept) begin
        step_live <= 1'b1;
      end else if (!emitting && !win_pend) begin
        step_live <= 1'b0;
      end
      if (do_emit) begin
        emit_cnt <= emit_cnt - FW'(1);
        emit_idx <= emit_idx + IW'(1);
      end else if (do_dec && hit && rlen_e != '0) begin
        emit_cnt <= rlen_e - FW'(1);
        emit_idx <= IW'(1);
      end
      if (do_dec) begin
        tally     <= tally_upd;
        prev_word <= hit ? word_last : word[0];
      end
      if (accept) begin
        step_n <= '0;
      end else if (req.push) begin
        step_n <= step_n + SW'(1);
      end
      if (accept && in_data.stream_end) begin
        end_active <= 1'b1;
      end
      if (do_done) begin
        end_active <= 1'b0;
        fill       <= '0;
        tally      <= '0;
        prev_word  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/swsr_cell.sv @@
// swsr_cell: one byte of the lookahead window with its pattern compare and word class
// depends on swsr_pkg
`default_nettype none

module swsr_cell import swsr_pkg::*; (
  input  logic       clk,
  input  logic       ld,
  input  logic [7:0] din,
  input  logic [7:0] pat,
  output logic [7:0] data,
  output logic       eq,
  output logic       word
);

  logic [7:0] held_byte;

  always_ff @(posedge clk) begin
    if (ld) begin
      held_byte <= din;
    end
  end

  assign data = held_byte;
  assign eq   = (held_byte == pat);
  assign word = is_word(held_byte);

endmodule

`default_nettype wire

@@ design/swsr_outq.sv @@
// swsr_outq: pending slot plus output register; holds the newest item of a closing stream
// depends on swsr_pkg
`default_nettype none

module swsr_outq import swsr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  oq_req_t   req,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      pend_valid;
  logic      pend_held;
  out_item_t pend_item;
  logic      out_free;
  logic      pend_move;

  assign out_free  = !out_valid || !out_stall;
  assign can_push  = !pend_valid || out_free;
  assign pend_move = pend_valid && out_free && (!pend_held || req.push);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_held  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= pend_move || (out_valid && out_stall);
      if (req.push) begin
        pend_valid <= 1'b1;
        pend_held  <= req.held;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (req.seal) begin
        pend_held <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_data <= pend_item;
    end
    if (req.push) begin
      pend_item <= req.item;
    end else if (req.seal) begin
      pend_item.last_of_stream <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ design/swsr_checker.sv @@
// swsr_checker: port-level assertions for the stream word search/replace block, with bind
// depends on swsr_pkg and stream_word_search_replace_top
`default_nettype none

module swsr_checker import swsr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data
);

  // a stalled input transaction stays and holds its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transaction changed while stalled");

  // a stalled transaction stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // an end marker carries no byte and always closes the stream
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_valid |-> out_data.last_of_stream && out_data.out_byte == 8'h00)
    else $error("end marker not last or carries a byte");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind stream_word_search_replace_top swsr_checker u_chk (.*);

`default_nettype wire
